>>> rtl/buddy_page_allocator_unit_assert.svh
// Assertion macros shared by the buddy allocator RTL.
// Expects clk_i and rst_ni in the including scope.
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpa assertion failed");

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpa assertion failed");

`endif

>>> rtl/bpa_pkg.sv
// Shared types, codes and helpers of the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int unsigned PC_W    = 17;  // page_count register
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned KB_W    = 19;
  localparam int unsigned ORD_W   = 5;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned PAGE_SH = 12;  // 4 KB pages
  localparam int unsigned PGW     = 21;  // working page index, holds PAGES itself

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BIG   = 2'd2;

  localparam logic CFG_PAGE_COUNT = 1'b0;
  localparam logic CFG_BASE_ADDR  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_BLD, S_A_SRCH, S_A_SCAN_RD, S_A_SCAN_CHK, S_A_SPLIT_RD,
    S_A_SPLIT_WR, S_F_RD, S_F_CHK, S_F_PUT_RD, S_F_PUT_WR, S_FIN
  } state_e;

  // position of the highest set bit
  function automatic logic [ORD_W-1:0] floor_log2(logic [PC_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < PC_W; i++) begin
      if (v[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

  // smallest w with 2^w >= p, p at least one
  function automatic logic [ORD_W-1:0] ceil_log2(logic [KB_W-2:0] p);
    logic [KB_W-2:0] m;
    logic [ORD_W-1:0] r;
    m = p - 1'b1;
    r = '0;
    for (int i = 0; i < KB_W - 1; i++) begin
      if (m[i]) r = ORD_W'(i + 1);
    end
    return r;
  endfunction

endpackage

>>> rtl/buddy_page_allocator_unit.sv
// Buddy page allocator: 4 KB pages, one free-head memory and per-order counts.
// Depends on bpa_pkg and buddy_page_allocator_unit_assert.svh.
//
// One transaction is taken at a time, s_axis_tready is high only when idle. After
// reset the head memory is swept clear before the first transaction is taken;
// a rebuild does the same sweep and then writes the free blocks one at a time.
// An allocation searches upward from the wanted order, scans the head memory at
// the first order with a non-zero count and splits the block that it finds down
// to the wanted order; a free merges with its buddy level by level. All memory
// traffic goes through the single read and single write port of the head RAM.
// Results leave through an output register, so the next transaction can start
// while a result waits on m_axis_tready.
module buddy_page_allocator_unit #(
  parameter int unsigned PAGES  = 65536,
  parameter int unsigned ORDERS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_kb[18:0], free_address[50:19], free_order[55:51]
  input  logic [55:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // block_address[31:0], block_order[36:32]
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  `include "buddy_page_allocator_unit_assert.svh"

  localparam int unsigned PW  = $clog2(PAGES);
  localparam int unsigned HW  = $clog2(ORDERS + 1);
  localparam int unsigned OIW = (ORDERS > 1) ? $clog2(ORDERS) : 1;
  localparam int unsigned CW  = $clog2(PAGES + 1);
  localparam logic [bpa_pkg::PGW-1:0] PagesW = bpa_pkg::PGW'(PAGES);
  localparam logic [bpa_pkg::ORD_W-1:0] TopOrd = bpa_pkg::ORD_W'(ORDERS - 1);

  // config
  logic [bpa_pkg::PC_W-1:0]   page_count_q;
  logic [bpa_pkg::ADDR_W-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= '0;
      base_q       <= 32'h0010_0000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bpa_pkg::CFG_PAGE_COUNT) page_count_q <= cfg_data_i[bpa_pkg::PC_W-1:0];
      else                                      base_q       <= cfg_data_i;
    end
  end

  // input fields
  logic [bpa_pkg::ACT_W-1:0]  in_action;
  logic [bpa_pkg::KB_W-1:0]   in_kb;
  logic [bpa_pkg::ADDR_W-1:0] in_addr;
  logic [bpa_pkg::ORD_W-1:0]  in_order;
  logic                       in_acc;

  assign in_action = s_axis_tuser;
  assign in_kb     = s_axis_tdata[18:0];
  assign in_addr   = s_axis_tdata[50:19];
  assign in_order  = s_axis_tdata[55:51];

  bpa_pkg::state_e state_q, state_d;
  logic [bpa_pkg::PGW-1:0]   pg_q, pg_d;
  logic [bpa_pkg::ORD_W-1:0] ord_q, ord_d, want_q, want_d, j_q, j_d;
  logic [bpa_pkg::PC_W-1:0]  left_q, left_d;
  logic                      bld_q, bld_d;
  logic [ORDERS-1:0][CW-1:0] cnt_q, cnt_d;
  logic [bpa_pkg::STAT_W-1:0] rs_stat_q, rs_stat_d;
  logic                      rs_ok_q, rs_ok_d;

  logic                       out_valid_q;
  logic [bpa_pkg::STAT_W-1:0] out_stat_q;
  logic [bpa_pkg::ADDR_W-1:0] out_addr_q;
  logic [bpa_pkg::ORD_W-1:0]  out_ord_q;
  logic                       out_load;

  // head memory
  logic [HW-1:0] mem [PAGES];
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_wa, mem_ra;
  logic [HW-1:0] mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= mem[mem_ra];
  end

  // decode helpers
  logic [bpa_pkg::PGW-1:0]   limit;
  logic [bpa_pkg::KB_W-2:0]  req_pages;
  logic [bpa_pkg::ORD_W-1:0] want;
  logic [bpa_pkg::PGW-1:0]   fpage, fbit, ord_bit, jm1_bit, buddy;
  logic [bpa_pkg::ADDR_W-1:0] rel;
  logic                      free_bad;
  logic [bpa_pkg::ORD_W-1:0] bld_ord;
  logic [HW-1:0]             ord_head;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign limit = ({4'd0, page_count_q} > PagesW) ? PagesW : {4'd0, page_count_q};

  always_comb begin
    logic [bpa_pkg::KB_W:0] kb3;
    logic [bpa_pkg::ORD_W-1:0] fl;
    kb3 = {1'b0, in_kb} + (bpa_pkg::KB_W+1)'(3);
    req_pages = kb3[bpa_pkg::KB_W:2];
    if (req_pages == '0) req_pages = (bpa_pkg::KB_W-1)'(1);
    want = bpa_pkg::ceil_log2(req_pages);
    rel   = in_addr - base_q;
    fpage = {1'b0, rel[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SH]};
    fbit  = bpa_pkg::PGW'(1) << in_order;
    free_bad = ((fpage & (fbit - 1'b1)) != '0) || (fpage >= limit) ||
               (fbit > limit - fpage);
    fl = bpa_pkg::floor_log2(left_q);
    bld_ord = (fl > TopOrd) ? TopOrd : fl;
  end

  assign ord_bit  = bpa_pkg::PGW'(1) << ord_q;
  assign jm1_bit  = bpa_pkg::PGW'(1) << (j_q - 1'b1);
  assign buddy    = pg_q ^ ord_bit;
  assign ord_head = HW'(ord_q) + 1'b1;
  assign out_load = !out_valid_q || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_action == bpa_pkg::ACT_ALLOC)
            state_d = (want > TopOrd) ? bpa_pkg::S_FIN : bpa_pkg::S_A_SRCH;
          else if (in_action == bpa_pkg::ACT_FREE)
            state_d = (in_order > TopOrd || free_bad) ? bpa_pkg::S_FIN : bpa_pkg::S_F_RD;
          else if (in_action == bpa_pkg::ACT_REBUILD)
            state_d = bpa_pkg::S_CLR;
          else
            state_d = bpa_pkg::S_FIN;
        end
      end
      bpa_pkg::S_CLR:
        if (pg_q == PagesW - 1'b1) state_d = bld_q ? bpa_pkg::S_BLD : bpa_pkg::S_IDLE;
      bpa_pkg::S_BLD:
        if (left_q == '0) state_d = bpa_pkg::S_FIN;
      bpa_pkg::S_A_SRCH: begin
        if (ord_q > TopOrd) state_d = bpa_pkg::S_FIN;
        else if (cnt_q[ord_q[OIW-1:0]] != '0) state_d = bpa_pkg::S_A_SCAN_RD;
      end
      bpa_pkg::S_A_SCAN_RD:
        state_d = (pg_q >= PagesW) ? bpa_pkg::S_A_SRCH : bpa_pkg::S_A_SCAN_CHK;
      bpa_pkg::S_A_SCAN_CHK:
        state_d = (mem_rd_q == ord_head) ? bpa_pkg::S_A_SPLIT_RD : bpa_pkg::S_A_SCAN_RD;
      bpa_pkg::S_A_SPLIT_RD:
        state_d = (j_q == want_q) ? bpa_pkg::S_FIN : bpa_pkg::S_A_SPLIT_WR;
      bpa_pkg::S_A_SPLIT_WR: state_d = bpa_pkg::S_A_SPLIT_RD;
      bpa_pkg::S_F_RD:
        state_d = (ord_q >= TopOrd || buddy >= PagesW) ? bpa_pkg::S_F_PUT_RD : bpa_pkg::S_F_CHK;
      bpa_pkg::S_F_CHK:
        state_d = (mem_rd_q == ord_head) ? bpa_pkg::S_F_RD : bpa_pkg::S_F_PUT_RD;
      bpa_pkg::S_F_PUT_RD: state_d = bpa_pkg::S_F_PUT_WR;
      bpa_pkg::S_F_PUT_WR: state_d = bpa_pkg::S_FIN;
      bpa_pkg::S_FIN:
        if (out_load) state_d = bpa_pkg::S_IDLE;
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic          dec_en, inc_en;
    logic [OIW-1:0] dec_idx, inc_idx;
    pg_d = pg_q; ord_d = ord_q; want_d = want_q; j_d = j_q; left_d = left_q;
    bld_d = bld_q; rs_stat_d = rs_stat_q; rs_ok_d = rs_ok_q;
    mem_we = 1'b0; mem_wa = pg_q[PW-1:0]; mem_wd = '0;
    mem_re = 1'b0; mem_ra = pg_q[PW-1:0];
    dec_en = 1'b0; dec_idx = ord_q[OIW-1:0];
    inc_en = 1'b0; inc_idx = ord_q[OIW-1:0];
    cnt_d = cnt_q;
    s_axis_tready = (state_q == bpa_pkg::S_IDLE);
    unique case (state_q)
      bpa_pkg::S_IDLE: begin
        if (in_acc) begin
          rs_stat_d = bpa_pkg::ST_OK;
          rs_ok_d   = 1'b0;
          if (in_action == bpa_pkg::ACT_ALLOC) begin
            want_d = want;
            ord_d  = want;
            if (want > TopOrd) rs_stat_d = bpa_pkg::ST_BIG;
          end else if (in_action == bpa_pkg::ACT_FREE) begin
            pg_d  = fpage;
            ord_d = in_order;
            if (in_order > TopOrd) rs_stat_d = bpa_pkg::ST_BIG;
            else if (free_bad)     rs_stat_d = bpa_pkg::ST_NOFIT;
          end else if (in_action == bpa_pkg::ACT_REBUILD) begin
            cnt_d  = '0;
            left_d = limit[bpa_pkg::PC_W-1:0];
            pg_d   = '0;
            bld_d  = 1'b1;
          end
        end
      end
      bpa_pkg::S_CLR: begin
        mem_we = 1'b1;
        pg_d   = (pg_q == PagesW - 1'b1) ? '0 : pg_q + 1'b1;
      end
      bpa_pkg::S_BLD: begin
        if (left_q != '0) begin
          mem_we  = 1'b1;
          mem_wd  = HW'(bld_ord) + 1'b1;
          inc_en  = 1'b1;
          inc_idx = bld_ord[OIW-1:0];
          pg_d    = pg_q + (bpa_pkg::PGW'(1) << bld_ord);
          left_d  = left_q - (bpa_pkg::PC_W'(1) << bld_ord);
        end
      end
      bpa_pkg::S_A_SRCH: begin
        if (ord_q > TopOrd) rs_stat_d = bpa_pkg::ST_NOFIT;
        else if (cnt_q[ord_q[OIW-1:0]] == '0) ord_d = ord_q + 1'b1;
        else pg_d = '0;
      end
      bpa_pkg::S_A_SCAN_RD: begin
        if (pg_q >= PagesW) ord_d = ord_q + 1'b1;
        else mem_re = 1'b1;
      end
      bpa_pkg::S_A_SCAN_CHK: begin
        if (mem_rd_q == ord_head) begin
          mem_we = 1'b1;
          dec_en = 1'b1;
          j_d    = ord_q;
        end else begin
          pg_d = pg_q + ord_bit;
        end
      end
      bpa_pkg::S_A_SPLIT_RD: begin
        mem_ra = PW'(pg_q + jm1_bit);
        if (j_q == want_q) begin
          rs_ok_d = 1'b1;
          ord_d   = want_q;
        end else begin
          mem_re = 1'b1;
        end
      end
      bpa_pkg::S_A_SPLIT_WR: begin
        mem_we  = 1'b1;
        mem_wa  = PW'(pg_q + jm1_bit);
        mem_wd  = HW'(j_q);
        dec_en  = (mem_rd_q != '0);
        dec_idx = OIW'(mem_rd_q - 1'b1);
        inc_en  = 1'b1;
        inc_idx = OIW'(j_q - 1'b1);
        j_d     = j_q - 1'b1;
      end
      bpa_pkg::S_F_RD: begin
        mem_ra = buddy[PW-1:0];
        if (!(ord_q >= TopOrd || buddy >= PagesW)) mem_re = 1'b1;
      end
      bpa_pkg::S_F_CHK: begin
        mem_wa = buddy[PW-1:0];
        if (mem_rd_q == ord_head) begin
          mem_we = 1'b1;
          dec_en = 1'b1;
          pg_d   = pg_q & ~ord_bit;
          ord_d  = ord_q + 1'b1;
        end
      end
      bpa_pkg::S_F_PUT_RD: mem_re = 1'b1;
      bpa_pkg::S_F_PUT_WR: begin
        mem_we  = 1'b1;
        mem_wd  = ord_head;
        dec_en  = (mem_rd_q != '0);
        dec_idx = OIW'(mem_rd_q - 1'b1);
        inc_en  = 1'b1;
        rs_ok_d = 1'b1;
      end
      bpa_pkg::S_FIN: bld_d = 1'b0;
      default: ;
    endcase
    // counts never go below zero; a stale head may point at an empty order
    if (dec_en && cnt_d[dec_idx] != '0) cnt_d[dec_idx] = cnt_d[dec_idx] - 1'b1;
    if (inc_en) cnt_d[inc_idx] = cnt_d[inc_idx] + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::S_CLR;
      pg_q        <= '0;
      bld_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pg_q    <= pg_d;
      bld_q   <= bld_d;
      cnt_q   <= cnt_d;
      if (state_q == bpa_pkg::S_FIN && out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready)                    out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q     <= ord_d;
    want_q    <= want_d;
    j_q       <= j_d;
    left_q    <= left_d;
    rs_stat_q <= rs_stat_d;
    rs_ok_q   <= rs_ok_d;
    if (state_q == bpa_pkg::S_FIN && out_load) begin
      out_stat_q <= rs_stat_q;
      out_addr_q <= rs_ok_q ?
                    base_q + {pg_q[bpa_pkg::ADDR_W-bpa_pkg::PAGE_SH-1:0], 12'd0} : '0;
      out_ord_q  <= rs_ok_q ? ord_q : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_ord_q, out_addr_q};
  assign m_axis_tuser  = out_stat_q;

  `BPA_ASSERT_NXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `BPA_ASSERT_IMP(a_fail_has_no_block,
    out_valid_q && out_stat_q != bpa_pkg::ST_OK, out_addr_q == '0 && out_ord_q == '0)
  `BPA_ASSERT_IMP(a_split_above_want, state_q == bpa_pkg::S_A_SPLIT_RD, j_q >= want_q)
  `BPA_ASSERT_NXT(a_counts_hold_idle,
    state_q == bpa_pkg::S_IDLE && !in_acc, $stable(cnt_q))

endmodule

>>> test/tb_top.sv
// Self-checking testbench for buddy_page_allocator_unit: directed and random
// allocate/free/rebuild traffic checked against an in-bench allocator model.
// Depends on bpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
  import bpa_pkg::*;

  localparam int unsigned NPAGES  = 65536;
  localparam int unsigned NORDERS = 17;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [31:0]       addr;
    logic [ORD_W-1:0]  order;
  } alloc_res_t;

  typedef struct {
    int unsigned page;
    int unsigned order;
  } live_blk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  buddy_page_allocator_unit dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // allocator model state
  logic [5:0]  free_heads [NPAGES];
  int unsigned order_counts [NORDERS];
  int unsigned pages_cfg;
  logic [31:0] base_cfg;

  alloc_res_t  expected_q [$];
  live_blk_t   live_blocks [$];
  int unsigned errors, n_items, n_results, n_alloc_ok, n_free_ok, n_merge, n_rebuild;
  bit          gaps_on = 1'b1;
  int unsigned rx_hold = 0;

  function automatic int unsigned page_lim();
    return (pages_cfg > NPAGES) ? NPAGES : pages_cfg;
  endfunction

  function automatic void head_put(int unsigned pg, int unsigned ord);
    logic [5:0] old;
    old = free_heads[pg];
    if (old != 0 && order_counts[old-1] != 0) order_counts[old-1]--;
    free_heads[pg] = 6'(ord + 1);
    order_counts[ord]++;
  endfunction

  function automatic void head_take(int unsigned pg);
    logic [5:0] old;
    old = free_heads[pg];
    if (old != 0 && order_counts[old-1] != 0) order_counts[old-1]--;
    free_heads[pg] = '0;
  endfunction

  function automatic alloc_res_t mk_res(logic [1:0] st, int unsigned pg, int unsigned ord,
                                        bit ok);
    alloc_res_t r;
    r.status = st;
    r.addr   = ok ? base_cfg + 32'(pg << PAGE_SH) : '0;
    r.order  = ok ? ORD_W'(ord) : '0;
    return r;
  endfunction

  function automatic alloc_res_t predict(logic [1:0] act, int unsigned kb, logic [31:0] fa,
                                         int unsigned ford);
    int unsigned pages, want, pg, lim, left, o;
    logic [31:0] rel;
    live_blk_t lb;
    if (act == ACT_ALLOC) begin
      pages = (kb + 3) / 4;
      if (pages == 0) pages = 1;
      want = 0;
      while ((1 << want) < pages && want < 31) want++;
      if (want > NORDERS - 1) return mk_res(ST_BIG, 0, 0, 0);
      for (int unsigned i = want; i < NORDERS; i++) begin
        if (order_counts[i] == 0) continue;
        for (pg = 0; pg < NPAGES; pg += (1 << i)) begin
          if (32'(free_heads[pg]) == i + 1) begin
            head_take(pg);
            for (int j = int'(i) - 1; j >= int'(want); j--) head_put(pg + (1 << j), j);
            n_alloc_ok++;
            lb.page = pg; lb.order = want;
            live_blocks.push_back(lb);
            return mk_res(ST_OK, pg, want, 1);
          end
        end
      end
      return mk_res(ST_NOFIT, 0, 0, 0);
    end else if (act == ACT_FREE) begin
      rel = fa - base_cfg;
      pg  = rel >> PAGE_SH;
      lim = page_lim();
      if (ford > NORDERS - 1) return mk_res(ST_BIG, 0, 0, 0);
      if ((pg & ((1 << ford) - 1)) != 0 || pg >= lim || (1 << ford) > lim - pg)
        return mk_res(ST_NOFIT, 0, 0, 0);
      o = ford;
      while (o < NORDERS - 1) begin
        if ((pg ^ (1 << o)) >= NPAGES || 32'(free_heads[pg ^ (1 << o)]) != o + 1) break;
        head_take(pg ^ (1 << o));
        pg &= ~(1 << o);
        o++;
        n_merge++;
      end
      head_put(pg, o);
      n_free_ok++;
      return mk_res(ST_OK, pg, o, 1);
    end else if (act == ACT_REBUILD) begin
      foreach (free_heads[k]) free_heads[k] = '0;
      foreach (order_counts[k]) order_counts[k] = 0;
      live_blocks.delete();
      left = page_lim();
      pg = 0;
      while (left > 0) begin
        o = 0;
        while (o + 1 < NORDERS && (2 << o) <= left) o++;
        head_put(pg, o);
        pg += 1 << o;
        left -= 1 << o;
      end
      n_rebuild++;
      return mk_res(ST_OK, 0, 0, 0);
    end
    return mk_res(ST_OK, 0, 0, 0);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, exp_v);
  endtask

  // result checker and receiver idling
  initial begin
    alloc_res_t e;
    int unsigned wait_cnt;
    wait_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata[31:0], '0);
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tuser != e.status)
            report_mismatch("status", 32'(m_axis_tuser), 32'(e.status));
          if (m_axis_tdata[31:0] != e.addr)
            report_mismatch("block_address", m_axis_tdata[31:0], e.addr);
          if (m_axis_tdata[36:32] != e.order)
            report_mismatch("block_order", 32'(m_axis_tdata[36:32]), 32'(e.order));
        end
        wait_cnt = gaps_on ? $urandom_range(0, 14) : 0;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (wait_cnt > 0) begin
        wait_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [18:0] kb, logic [31:0] fa, logic [4:0] ford);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {ford, fa, kb};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(predict(act, 32'(kb), fa, 32'(ford)));
    n_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0 || !s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PAGE_COUNT) pages_cfg = val & 32'h1FFFF;
    else base_cfg = val;
  endtask

  function automatic logic [31:0] blk_addr_of(int unsigned pg);
    return base_cfg + 32'(pg << PAGE_SH);
  endfunction

  task automatic test_directed();
    write_cfg(CFG_PAGE_COUNT, 100);
    send_item(ACT_ALLOC, 1, 0, 0);           // empty store before any rebuild
    send_item(ACT_REBUILD, 0, 0, 0);
    send_item(ACT_ALLOC, 0, 0, 0);           // zero size takes one page
    send_item(ACT_ALLOC, 1, 0, 0);
    send_item(ACT_ALLOC, 5, 0, 0);
    send_item(ACT_ALLOC, 8192, 0, 0);        // larger than anything free
    send_item(ACT_ALLOC, 19'h7FFFF, 0, 0);   // above top order
    send_item(ACT_ALLOC, 262144, 0, 0);      // exactly top order, no fit
    send_item(ACT_FREE, 0, blk_addr_of(0), 17);
    send_item(ACT_FREE, 0, blk_addr_of(0), 31);
    send_item(ACT_FREE, 0, blk_addr_of(1), 1);  // misaligned
    send_item(ACT_FREE, 0, blk_addr_of(96), 3); // runs past page_count
    send_item(ACT_FREE, 0, blk_addr_of(200), 0);
    send_item(ACT_FREE, 0, 32'h0, 0);        // below base, wraps
    send_item(ACT_FREE, 0, blk_addr_of(0) | 32'hFFF, 0);
    send_item(ACT_FREE, 0, blk_addr_of(0), 0);  // double free
    send_item(ACT_FREE, 0, blk_addr_of(1), 0);  // merges upward
    send_item(2'd3, 19'h7FFFF, 32'hFFFFFFFF, 5'h1F);
    send_item(ACT_ALLOC, 256, 0, 0);
    send_item(ACT_ALLOC, 4, 0, 0);
    send_item(ACT_FREE, 0, blk_addr_of(64), 5);
    send_item(ACT_FREE, 0, blk_addr_of(99), 0);
  endtask

  task automatic random_item();
    int unsigned r, lim, idx;
    live_blk_t lb;
    lim = page_lim();
    r = $urandom_range(0, 199);
    if (r < 2) begin
      send_item(ACT_REBUILD, 19'($urandom), $urandom, 5'($urandom));
    end else if (r < 12) begin
      send_item(2'($urandom), 19'($urandom), $urandom, 5'($urandom));
    end else if (r < 100) begin
      if ($urandom_range(0, 9) == 0) send_item(ACT_ALLOC, 19'($urandom), $urandom, 5'($urandom));
      else send_item(ACT_ALLOC, 19'($urandom_range(0, 4 * (lim < 64 ? lim : 64) + 4)),
                     $urandom, 5'($urandom));
    end else if (live_blocks.size() != 0 && r < 190) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      lb = live_blocks[idx];
      if ($urandom_range(0, 15) != 0) live_blocks.delete(idx);
      send_item(ACT_FREE, 19'($urandom), blk_addr_of(lb.page) | 32'($urandom_range(0, 4095)),
                5'(lb.order));
    end else begin
      send_item(ACT_FREE, 19'($urandom),
                $urandom_range(0, 1) ? blk_addr_of($urandom_range(0, lim + 2)) : $urandom,
                5'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom));
    end
  endtask

  task automatic test_random_phases();
    logic [31:0] pcs [6] = '{64, 1, 37, 65536, 32'h1FFFF, 513};
    logic [31:0] bases [6] = '{32'h100000, 32'hFFFFF000, 32'h12345ABC, 0,
                               32'hFFFFFFFF, 32'h80000000};
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_BASE_ADDR, bases[ph]);
      write_cfg(CFG_PAGE_COUNT, pcs[ph]);
      gaps_on = (ph != 2);
      send_item(ACT_REBUILD, 0, 0, 0);
      // shrink the limit without rebuilding in one phase
      if (ph == 4) write_cfg(CFG_PAGE_COUNT, 300);
      repeat (ph == 3 || ph == 4 ? 150 : 250) random_item();
    end
    gaps_on = 1'b1;
    write_cfg(CFG_PAGE_COUNT, 0);
    send_item(ACT_REBUILD, 0, 0, 0);
    repeat (20) random_item();
  endtask

  task automatic test_backpressure();
    write_cfg(CFG_BASE_ADDR, 32'h00400000);
    write_cfg(CFG_PAGE_COUNT, 128);
    send_item(ACT_REBUILD, 0, 0, 0);
    drain();
    rx_hold = 400;
    gaps_on = 1'b0;
    repeat (30) random_item();
    gaps_on = 1'b1;
  endtask

  initial begin
    foreach (free_heads[k]) free_heads[k] = '0;
    foreach (order_counts[k]) order_counts[k] = 0;
    pages_cfg = 0;
    base_cfg = 32'h100000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d transactions in, %0d out: %0d allocs, %0d frees, %0d merges",
             n_items, n_results, n_alloc_ok, n_free_ok, n_merge);
    $display("%0d rebuilds over several page counts and base addresses", n_rebuild);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1000000000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
